@@ rtl/cspr_pkg.sv @@
// Shared types and constants for the 2-D convolution engine.
package cspr_pkg;

  localparam int DATA_W    = 16;
  localparam int ACC_W     = 48;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int MAX_SIDE  = 32;
  localparam int MAX_CIN   = 16;
  localparam int MAX_COUT  = 16;
  localparam int MAX_K     = 5;
  localparam int MAP_DEPTH = MAX_SIDE * MAX_SIDE * MAX_CIN;
  localparam int WGT_DEPTH = MAX_K * MAX_K * MAX_CIN * MAX_COUT;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int WGT_AW    = $clog2(WGT_DEPTH);
  localparam int BIAS_AW   = $clog2(MAX_COUT);

  localparam logic [1:0] MODE_MAP  = 2'd0;
  localparam logic [1:0] MODE_WGT  = 2'd1;
  localparam logic [1:0] MODE_BIAS = 2'd2;
  localparam logic [1:0] MODE_RUN  = 2'd3;

  localparam logic [2:0] REG_HIN     = 3'd0;
  localparam logic [2:0] REG_WIN     = 3'd1;
  localparam logic [2:0] REG_CIN     = 3'd2;
  localparam logic [2:0] REG_COUT    = 3'd3;
  localparam logic [2:0] REG_KX      = 3'd4;
  localparam logic [2:0] REG_KY      = 3'd5;
  localparam logic [2:0] REG_STRIDES = 3'd6;
  localparam logic [2:0] REG_FLAGS   = 3'd7;

  typedef struct packed {
    logic [1:0]               mode;
    logic [13:0]              index;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] out_value;
    logic [13:0]        out_index;
    logic               last;
    logic               geometry_error;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_MAP,
    OP_WGT,
    OP_BIAS,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [13:0]              addr;
    logic signed [DATA_W-1:0] data;
  } q_item_t;

  typedef struct packed {
    logic [5:0] hin;
    logic [5:0] win;
    logic [4:0] cin;
    logic [4:0] cout;
    logic [2:0] kx;
    logic [2:0] ky;
    logic [7:0] strides;
    logic [1:0] flags;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_IDX,
    ST_TAPA,
    ST_TAPB,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

@@ rtl/cspr_front.sv @@
// Front end: accepts beats, classifies them, drops out-of-range loads, queues the rest.
module cspr_front
  import cspr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  q_item_t    q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       keep, push;
  q_item_t    cls;

  always_comb begin
    cls.addr = in_data.index;
    cls.data = in_data.value;
    unique case (in_data.mode)
      MODE_MAP: begin
        cls.op = OP_MAP;
        keep   = 1'b1;
      end
      MODE_WGT: begin
        cls.op = OP_WGT;
        keep   = (32'(in_data.index) < WGT_DEPTH);
      end
      MODE_BIAS: begin
        cls.op = OP_BIAS;
        keep   = (32'(in_data.index) < MAX_COUT);
      end
      default: begin
        cls.op = OP_RUN;
        keep   = 1'b1;
      end
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
  end

endmodule

@@ rtl/cspr_back.sv @@
// Back end: stores, output-size divider, window sequencer, shared MAC and result register.
module cspr_back
  import cspr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cfg_clr,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [DATA_W-1:0] map_mem [MAP_DEPTH];
  logic [DATA_W-1:0] wgt_mem [WGT_DEPTH];
  logic signed [DATA_W-1:0] bias_r [MAX_COUT];
  logic signed [DATA_W-1:0] map_q_r, wgt_q_r;
  logic signed [PROD_W-1:0] prod_r;

  state_t state_r, state_nxt;
  logic err_r, err_nxt;
  logic [6:0] numw_r, numw_nxt, numh_r, numh_nxt;
  logic [5:0] qw_r, qw_nxt, qh_r, qh_nxt;
  logic [3:0] co_r, co_nxt;
  logic [4:0] ri_r, ri_nxt, cj_r, cj_nxt;
  logic signed [10:0] rb_r, rb_nxt, cb_r, cb_nxt;
  logic [9:0] po_r, po_nxt, pix_r, pix_nxt;
  logic [13:0] oidx_r, oidx_nxt;
  logic [2:0] ii_r, ii_nxt, jj_r, jj_nxt;
  logic [4:0] t_r, t_nxt;
  logic [8:0] tcin_r, tcin_nxt;
  logic [MAP_AW-1:0] fa_r, fa_nxt;
  logic [WGT_AW-1:0] wa_r, wa_nxt;
  logic [3:0] c_r, c_nxt;
  logic rdv_r, pv_r, issue;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic map_we, wgt_we, bias_we;
  logic [3:0] sx, sy;
  logic [2:0] px, py;
  logic [6:0] padw, padh;
  logic geo_bad, room, last_tap, bad_cur, last_out;
  logic [5:0] wout, hout;
  logic [3:0] co_n;
  logic [4:0] ri_n, cj_n;
  logic [8:0] rs, cs;
  logic [10:0] pw, pixw;
  logic [14:0] oid, faw;
  logic [13:0] waw;
  logic [9:0] tcw;
  logic signed [10:0] hh, ww;
  logic inb;
  logic signed [ACC_W-1:0] sum;

  assign sx   = cfg.strides[3:0];
  assign sy   = cfg.strides[7:4];
  assign px   = cfg.flags[0] ? 3'((cfg.kx - 3'd1) >> 1) : 3'd0;
  assign py   = cfg.flags[0] ? 3'((cfg.ky - 3'd1) >> 1) : 3'd0;
  assign padw = 7'(cfg.win) + 7'({px, 1'b0});
  assign padh = 7'(cfg.hin) + 7'({py, 1'b0});
  assign geo_bad = (cfg.hin == 6'd0) || (32'(cfg.hin) > MAX_SIDE) ||
                   (cfg.win == 6'd0) || (32'(cfg.win) > MAX_SIDE) ||
                   (cfg.cin == 5'd0) || (32'(cfg.cin) > MAX_CIN) ||
                   (cfg.cout == 5'd0) || (32'(cfg.cout) > MAX_COUT) ||
                   (cfg.kx == 3'd0) || (32'(cfg.kx) > MAX_K) ||
                   (cfg.ky == 3'd0) || (32'(cfg.ky) > MAX_K) ||
                   (sx == 4'd0) || (sy == 4'd0) ||
                   (padw < 7'(cfg.kx)) || (padh < 7'(cfg.ky));
  assign wout = qw_r + 6'd1;
  assign hout = qh_r + 6'd1;
  assign room = !out_valid_r || !out_stall;
  assign last_tap = (jj_r == cfg.kx - 3'd1) && (ii_r == cfg.ky - 3'd1);
  assign last_out = (5'(co_r) + 5'd1 == cfg.cout) && (6'(ri_r) + 6'd1 == hout) &&
                    (6'(cj_r) + 6'd1 == wout);

  always_comb begin
    bad_cur = (5'(co_r) >= cfg.cout) || (6'(ri_r) >= hout) || (6'(cj_r) >= wout);
    co_n = bad_cur ? 4'd0 : co_r;
    ri_n = bad_cur ? 5'd0 : ri_r;
    cj_n = bad_cur ? 5'd0 : cj_r;
    rs   = ri_n * sy;
    cs   = cj_n * sx;
    pw   = ri_n * wout;
    oid  = po_r * cfg.cout + 15'(co_r);
    hh   = rb_r + $signed({8'b0, ii_r});
    ww   = cb_r + $signed({8'b0, jj_r});
    inb  = !hh[10] && !ww[10] && (hh[9:0] < 10'(cfg.hin)) && (ww[9:0] < 10'(cfg.win));
    pixw = hh[4:0] * cfg.win + 11'(ww[4:0]);
    tcw  = t_r * cfg.cin;
    faw  = pix_r * cfg.cin;
    waw  = tcin_r * cfg.cout + 14'(co_r);
    sum  = acc_r + ACC_W'(bias_r[co_r]);
    if (cfg.flags[1] && sum[ACC_W-1]) sum = '0;
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt = err_r;
    numw_nxt = numw_r; numh_nxt = numh_r;
    qw_nxt = qw_r; qh_nxt = qh_r;
    co_nxt = co_r; ri_nxt = ri_r; cj_nxt = cj_r;
    rb_nxt = rb_r; cb_nxt = cb_r;
    po_nxt = po_r; oidx_nxt = oidx_r;
    ii_nxt = ii_r; jj_nxt = jj_r; t_nxt = t_r;
    pix_nxt = pix_r; tcin_nxt = tcin_r;
    fa_nxt = fa_r; wa_nxt = wa_r; c_nxt = c_r;
    issue = 1'b0;
    acc_nxt = pv_r ? acc_r + ACC_W'(prod_r) : acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    q_pop = 1'b0;
    map_we = 1'b0; wgt_we = 1'b0; bias_we = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_MAP:  map_we = 1'b1;
            OP_WGT:  wgt_we = 1'b1;
            OP_BIAS: bias_we = 1'b1;
            default: begin
              err_nxt  = geo_bad;
              numw_nxt = padw - 7'(cfg.kx);
              numh_nxt = padh - 7'(cfg.ky);
              qw_nxt = 6'd0;
              qh_nxt = 6'd0;
              state_nxt = geo_bad ? ST_FIN : ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (numw_r >= 7'(sx)) begin
          numw_nxt = numw_r - 7'(sx);
          qw_nxt = qw_r + 6'd1;
        end
        if (numh_r >= 7'(sy)) begin
          numh_nxt = numh_r - 7'(sy);
          qh_nxt = qh_r + 6'd1;
        end
        if (numw_r < 7'(sx) && numh_r < 7'(sy)) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        co_nxt = co_n; ri_nxt = ri_n; cj_nxt = cj_n;
        rb_nxt = $signed({2'b0, rs}) - $signed({8'b0, py});
        cb_nxt = $signed({2'b0, cs}) - $signed({8'b0, px});
        po_nxt = 10'(pw + 11'(cj_n));
        acc_nxt = '0;
        ii_nxt = 3'd0; jj_nxt = 3'd0; t_nxt = 5'd0;
        state_nxt = ST_IDX;
      end
      ST_IDX: begin
        oidx_nxt = 14'(oid);
        state_nxt = ST_TAPA;
      end
      ST_TAPA: begin
        pix_nxt = 10'(pixw);
        tcin_nxt = 9'(tcw);
        if (inb) begin
          state_nxt = ST_TAPB;
        end else if (last_tap) begin
          state_nxt = ST_DRAIN;
        end else begin
          t_nxt = t_r + 5'd1;
          if (jj_r == cfg.kx - 3'd1) begin
            jj_nxt = 3'd0;
            ii_nxt = ii_r + 3'd1;
          end else begin
            jj_nxt = jj_r + 3'd1;
          end
        end
      end
      ST_TAPB: begin
        fa_nxt = MAP_AW'(faw);
        wa_nxt = WGT_AW'(waw);
        c_nxt = 4'd0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        issue = 1'b1;
        fa_nxt = fa_r + MAP_AW'(1);
        wa_nxt = wa_r + WGT_AW'(cfg.cout);
        c_nxt = c_r + 4'd1;
        if (c_r == 4'(cfg.cin - 5'd1)) begin
          if (last_tap) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_TAPA;
            t_nxt = t_r + 5'd1;
            if (jj_r == cfg.kx - 3'd1) begin
              jj_nxt = 3'd0;
              ii_nxt = ii_r + 3'd1;
            end else begin
              jj_nxt = jj_r + 3'd1;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!rdv_r && !pv_r) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (room) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
          if (err_r) begin
            out_data_nxt.out_value = '0;
            out_data_nxt.out_index = '0;
            out_data_nxt.last = 1'b1;
            out_data_nxt.geometry_error = 1'b1;
            co_nxt = 4'd0; ri_nxt = 5'd0; cj_nxt = 5'd0;
          end else begin
            out_data_nxt.out_value = 48'(sum);
            out_data_nxt.out_index = oidx_r;
            out_data_nxt.last = last_out;
            out_data_nxt.geometry_error = 1'b0;
            if (6'(cj_r) + 6'd1 >= wout) begin
              cj_nxt = 5'd0;
              if (6'(ri_r) + 6'd1 >= hout) begin
                ri_nxt = 5'd0;
                co_nxt = (5'(co_r) + 5'd1 >= cfg.cout) ? 4'd0 : co_r + 4'd1;
              end else begin
                ri_nxt = ri_r + 5'd1;
              end
            end else begin
              cj_nxt = cj_r + 5'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_clr) begin
      co_nxt = 4'd0; ri_nxt = 5'd0; cj_nxt = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      co_r <= 4'd0;
      ri_r <= 5'd0;
      cj_r <= 5'd0;
      rdv_r <= 1'b0;
      pv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      co_r <= co_nxt;
      ri_r <= ri_nxt;
      cj_r <= cj_nxt;
      rdv_r <= issue;
      pv_r <= rdv_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    numw_r <= numw_nxt; numh_r <= numh_nxt;
    qw_r <= qw_nxt; qh_r <= qh_nxt;
    rb_r <= rb_nxt; cb_r <= cb_nxt;
    po_r <= po_nxt; oidx_r <= oidx_nxt;
    ii_r <= ii_nxt; jj_r <= jj_nxt; t_r <= t_nxt;
    pix_r <= pix_nxt; tcin_r <= tcin_nxt;
    fa_r <= fa_nxt; wa_r <= wa_nxt; c_r <= c_nxt;
    acc_r <= acc_nxt;
    out_data_r <= out_data_nxt;
    prod_r <= map_q_r * wgt_q_r;
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[MAP_AW'(q_item.addr)] <= q_item.data;
    map_q_r <= map_mem[fa_r];
  end

  always_ff @(posedge clk) begin
    if (wgt_we) wgt_mem[WGT_AW'(q_item.addr)] <= q_item.data;
    wgt_q_r <= wgt_mem[wa_r];
  end

  always_ff @(posedge clk) begin
    if (bias_we) bias_r[BIAS_AW'(q_item.addr)] <= q_item.data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/conv2d_stride_pad_relu.sv @@
// Top level: configuration registers, front queue and compute back end.
// Load beats (input, weight, bias words) are written to the stores by the back end
// and produce no result. Each compute beat yields one result. The back end first
// finds the two output-size quotients by repeated subtraction (one subtract per
// cycle), then walks the window taps, skipping those outside the map; the single
// shared multiply-accumulate and the one read port of each store take the input
// channels of each tap one after another.
// A two-entry queue keeps the input side open while a compute beat runs, and a
// result register lets the next beat start while a result waits to be taken.
module conv2d_stride_pad_relu
  import cspr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cfg_t    cfg_r;
  logic    q_valid, q_pop;
  q_item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hin     <= 6'd1;
      cfg_r.win     <= 6'd1;
      cfg_r.cin     <= 5'd1;
      cfg_r.cout    <= 5'd1;
      cfg_r.kx      <= 3'd1;
      cfg_r.ky      <= 3'd1;
      cfg_r.strides <= 8'h11;
      cfg_r.flags   <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIN:     cfg_r.hin     <= cfg_data[5:0];
        REG_WIN:     cfg_r.win     <= cfg_data[5:0];
        REG_CIN:     cfg_r.cin     <= cfg_data[4:0];
        REG_COUT:    cfg_r.cout    <= cfg_data[4:0];
        REG_KX:      cfg_r.kx      <= cfg_data[2:0];
        REG_KY:      cfg_r.ky      <= cfg_data[2:0];
        REG_STRIDES: cfg_r.strides <= cfg_data;
        REG_FLAGS:   cfg_r.flags   <= cfg_data[1:0];
        default:     cfg_r.flags   <= cfg_r.flags;
      endcase
    end
  end

  cspr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  cspr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_clr   (cfg_we),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.geometry_error |->
      out_data.last && out_data.out_index == 14'd0 && out_data.out_value == 48'sd0)
    else $error("geometry error result malformed");

  a_relu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_r.flags[1] |-> !out_data.out_value[47])
    else $error("negative result with relu enabled");

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) && rst_n && $past(rst_n) |-> out_valid && $stable(out_data))
    else $error("stalled result changed");
`endif

endmodule

@@ tb/conv2d_stride_pad_relu_tb.sv @@
// Self-checking testbench for the 2-D convolution engine with stride, padding and ReLU.
module conv2d_stride_pad_relu_tb;
  import cspr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class conv_predictor;
    logic signed [DATA_W-1:0] map_mem[MAP_DEPTH];
    logic signed [DATA_W-1:0] wgt_mem[WGT_DEPTH];
    logic signed [DATA_W-1:0] bias_mem[MAX_COUT];
    int hin = 1, win = 1, cin = 1, cout = 1, kx = 1, ky = 1, strides = 'h11, flags = 0;
    int cur_co, cur_row, cur_col;
    out_item_t expected_outputs[$];
    int errors;

    function void write_reg(logic [2:0] idx, logic [7:0] data);
      case (idx)
        REG_HIN:     hin = data[5:0];
        REG_WIN:     win = data[5:0];
        REG_CIN:     cin = data[4:0];
        REG_COUT:    cout = data[4:0];
        REG_KX:      kx = data[2:0];
        REG_KY:      ky = data[2:0];
        REG_STRIDES: strides = data;
        REG_FLAGS:   flags = data[1:0];
        default: ;
      endcase
      cur_co = 0; cur_row = 0; cur_col = 0;
    endfunction

    function int pad_x();
      return flags[0] ? (kx - 1) / 2 : 0;
    endfunction

    function int pad_y();
      return flags[0] ? (ky - 1) / 2 : 0;
    endfunction

    function bit geom_ok();
      return !(hin < 1 || hin > MAX_SIDE || win < 1 || win > MAX_SIDE ||
               cin < 1 || cin > MAX_CIN || cout < 1 || cout > MAX_COUT ||
               kx < 1 || kx > MAX_K || ky < 1 || ky > MAX_K ||
               strides[3:0] == 0 || strides[7:4] == 0 ||
               win + 2 * pad_x() < kx || hin + 2 * pad_y() < ky);
    endfunction

    function int out_w();
      return (win + 2 * pad_x() - kx) / strides[3:0] + 1;
    endfunction

    function int out_h();
      return (hin + 2 * pad_y() - ky) / strides[7:4] + 1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      int px, py, wo, ho, co, i, j, h, w;
      logic [47:0] sum;
      logic signed [31:0] p;
      case (it.mode)
        MODE_MAP:  map_mem[it.index] = it.value;
        MODE_WGT:  if (it.index < WGT_DEPTH) wgt_mem[it.index] = it.value;
        MODE_BIAS: if (it.index < MAX_COUT) bias_mem[it.index] = it.value;
        default: begin
          e = '0;
          if (!geom_ok()) begin
            e.last = 1'b1;
            e.geometry_error = 1'b1;
            cur_co = 0; cur_row = 0; cur_col = 0;
            expected_outputs.push_back(e);
            return;
          end
          px = pad_x(); py = pad_y(); wo = out_w(); ho = out_h();
          co = cur_co; i = cur_row; j = cur_col;
          if (co >= cout || i >= ho || j >= wo) begin
            co = 0; i = 0; j = 0;
          end
          sum = '0;
          for (int ii = 0; ii < ky; ii++)
            for (int jj = 0; jj < kx; jj++) begin
              h = i * strides[7:4] + ii - py;
              w = j * strides[3:0] + jj - px;
              if (h >= 0 && w >= 0 && h < hin && w < win)
                for (int c = 0; c < cin; c++) begin
                  p = map_mem[(h * win + w) * cin + c] *
                      wgt_mem[((ii * kx + jj) * cin + c) * cout + co];
                  sum = sum + {{16{p[31]}}, p};
                end
            end
          sum = sum + {{32{bias_mem[co][15]}}, bias_mem[co]};
          if (flags[1] && sum[47]) sum = '0;
          e.out_value = sum;
          e.out_index = 14'((i * wo + j) * cout + co);
          e.last = (co + 1 == cout) && (i + 1 == ho) && (j + 1 == wo);
          expected_outputs.push_back(e);
          j++;
          if (j >= wo) begin
            j = 0; i++;
            if (i >= ho) begin
              i = 0; co++;
              if (co >= cout) co = 0;
            end
          end
          cur_co = co; cur_row = i; cur_col = j;
        end
      endcase
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, r);
        errors++;
        return;
      end
      e = expected_outputs.pop_front();
      if (e.out_value !== r.out_value) begin
        $display("%0t: out_value exp %0d got %0d", $time, e.out_value, r.out_value);
        errors++;
      end
      if (e.out_index !== r.out_index) begin
        $display("%0t: out_index exp %0d got %0d", $time, e.out_index, r.out_index);
        errors++;
      end
      if (e.last !== r.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, r.last);
        errors++;
      end
      if (e.geometry_error !== r.geometry_error) begin
        $display("%0t: geometry_error exp %0b got %0b", $time, e.geometry_error,
                 r.geometry_error);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 700;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;

  conv_predictor pred = new();
  int idle_cycles = 0;
  int results_taken = 0;
  int sent_items;
  bit quiet;

  conv2d_stride_pad_relu DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred.note_input(in_data);
      end
      if (out_valid && !out_stall) begin
        pred.check_result(out_data);
        results_taken <= results_taken + 1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("conv2d_stride_pad_relu: mismatch");
        $finish;
      end
    end
  end

  // result side: random hold-off per beat, one long hold-off to back the block up
  initial begin
    int k;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      k = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (results_taken == 40) k = 3000;
      if (k > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (k - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send(logic [1:0] m, int idx, logic [15:0] v);
    in_item_t it;
    int gap;
    it.mode = m;
    it.index = idx[13:0];
    it.value = v;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    logic [7:0] keep;
    case (idx)
      REG_HIN, REG_WIN:  keep = 8'h3f;
      REG_CIN, REG_COUT: keep = 8'h1f;
      REG_KX, REG_KY:    keep = 8'h07;
      REG_FLAGS:         keep = 8'h03;
      default:           keep = 8'hff;
    endcase
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (8'(val) & keep) | (8'($urandom) & ~keep);
    @(negedge clk);
    cfg_we <= 1'b0;
    pred.write_reg(idx, cfg_data);
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pred.expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // full reconfiguration, load every word a valid layer reads, then compute beats
  task automatic run_layer(int h, int w, int ci, int co, int kxv, int kyv, int st, int fl,
                           int ncomp);
    int n, r;
    wait_idle();
    write_reg(REG_HIN, h);
    write_reg(REG_WIN, w);
    write_reg(REG_CIN, ci);
    write_reg(REG_COUT, co);
    write_reg(REG_KX, kxv);
    write_reg(REG_KY, kyv);
    write_reg(REG_STRIDES, st);
    write_reg(REG_FLAGS, fl);
    if (pred.geom_ok()) begin
      for (int a = 0; a < h * w * ci; a++) send(MODE_MAP, a, 16'($urandom));
      for (int a = 0; a < kxv * kyv * ci * co; a++) send(MODE_WGT, a, 16'($urandom));
      for (int a = 0; a < co; a++) send(MODE_BIAS, a, 16'($urandom));
      n = (ncomp < 0) ? pred.out_w() * pred.out_h() * co + $urandom_range(0, 3) : ncomp;
    end else begin
      n = (ncomp < 0) ? $urandom_range(1, 3) : ncomp;
    end
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send(MODE_MAP, $urandom_range(0, MAP_DEPTH - 1), 16'($urandom));
      else if (r == 1) send(MODE_WGT, $urandom_range(WGT_DEPTH, 16383), 16'($urandom));
      else if (r == 2) send(MODE_BIAS, $urandom_range(MAX_COUT, 16383), 16'($urandom));
      send(MODE_RUN, $urandom_range(0, 16383), 16'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    sent_items = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // reset geometry: 1x1 map, 1x1 kernel, one channel
    send(MODE_MAP, 0, 16'h8000);
    send(MODE_WGT, 0, 16'h8000);
    send(MODE_BIAS, 0, 16'h7fff);
    send(MODE_RUN, 0, 16'h0000);
    send(MODE_WGT, 0, 16'h7fff);
    send(MODE_MAP, 16383, 16'hffff);
    send(MODE_WGT, WGT_DEPTH - 1, 16'h1234);
    send(MODE_WGT, WGT_DEPTH, 16'h5555);
    send(MODE_WGT, 16383, 16'haaaa);
    send(MODE_BIAS, MAX_COUT - 1, 16'h8001);
    send(MODE_BIAS, MAX_COUT, 16'h0001);
    send(MODE_BIAS, 16383, 16'hffff);
    send(MODE_RUN, 16383, 16'hffff);
    wait_idle();
    write_reg(REG_FLAGS, 2);
    send(MODE_MAP, 0, 16'h7fff);
    send(MODE_WGT, 0, 16'h8000);
    send(MODE_RUN, 0, 16'h0000);
    send(MODE_BIAS, 0, 16'h0005);
    send(MODE_WGT, 0, 16'h0001);
    send(MODE_RUN, 0, 16'h0000);

    // bad geometry: zero strides, out-of-range sizes, oversized kernel
    run_layer(4, 4, 1, 1, 1, 1, 'h10, 0, 2);
    run_layer(4, 4, 1, 1, 1, 1, 'h01, 0, 2);
    run_layer(4, 4, 1, 1, 1, 1, 'h00, 0, 2);
    run_layer(0, 4, 1, 1, 1, 1, 'h11, 0, 2);
    run_layer(33, 4, 1, 1, 1, 1, 'h11, 0, 2);
    run_layer(4, 0, 1, 1, 1, 1, 'h11, 0, 1);
    run_layer(4, 63, 1, 1, 1, 1, 'h11, 0, 1);
    run_layer(4, 4, 0, 1, 1, 1, 'h11, 0, 1);
    run_layer(4, 4, 17, 1, 1, 1, 'h11, 0, 1);
    run_layer(4, 4, 1, 0, 1, 1, 'h11, 0, 1);
    run_layer(4, 4, 1, 31, 1, 1, 'h11, 0, 1);
    run_layer(4, 4, 1, 1, 0, 1, 'h11, 0, 1);
    run_layer(4, 4, 1, 1, 6, 1, 'h11, 1, 1);
    run_layer(4, 4, 1, 1, 1, 7, 'h11, 0, 1);
    run_layer(2, 2, 1, 1, 5, 1, 'h11, 0, 2);
    run_layer(2, 2, 1, 1, 1, 5, 'h11, 2, 2);

    // largest kernel and channel count, back to back, a few outputs only
    quiet = 1'b1;
    run_layer(2, 2, MAX_CIN, 1, MAX_K, MAX_K, 'h11, 3, 3);
    quiet = 1'b0;
    run_layer(MAX_SIDE, 2, 1, 1, 1, 1, 'hff, 0, -1);
    run_layer(3, 3, 2, 2, 3, 3, 'h11, 1, -1);

    while (sent_items < 900) begin
      quiet = ($urandom_range(0, 4) == 0);
      run_layer($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 3),
                $urandom_range(1, 3), $urandom_range(1, 5), $urandom_range(1, 5),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                  : ($urandom_range(1, 3) << 4) | $urandom_range(1, 3),
                $urandom_range(0, 3), -1);
    end
    quiet = 1'b0;
    wait_idle();
    if (pred.errors == 0 && pred.expected_outputs.size() == 0) begin
      $display("conv2d_stride_pad_relu: match");
    end else begin
      $display("conv2d_stride_pad_relu: mismatch");
    end
    $finish;
  end

endmodule

@@ conv2d_stride_pad_relu.f @@
rtl/cspr_pkg.sv
rtl/cspr_front.sv
rtl/cspr_back.sv
rtl/conv2d_stride_pad_relu.sv
tb/conv2d_stride_pad_relu_tb.sv
